// ----- hw/rtl/bavg_pkg.sv -----
// ----------------------------------------------------------------------------
// bavg_pkg
// Shared types and constants for the block average downsampler.
// ----------------------------------------------------------------------------
package bavg_pkg;

  localparam int BAVG_MAX_WIDTH  = 4096;
  localparam int BAVG_MAX_FACTOR = 16;
  localparam int BAVG_PIX_BITS   = 8;
  localparam int BAVG_ROW_LIMIT  = 4096;

  localparam int BAVG_SUM_BITS   = 16;
  localparam int BAVG_ROW_BITS   = 12;
  localparam int BAVG_OFF_BITS   = $clog2(BAVG_MAX_FACTOR);
  localparam int BAVG_FAC_BITS   = 5;
  localparam int BAVG_DIM_BITS   = 13;
  localparam int BAVG_CNT_BITS   = 9;

  localparam logic [BAVG_DIM_BITS-1:0] BAVG_RST_WIDTH  = 13'd640;
  localparam logic [BAVG_DIM_BITS-1:0] BAVG_RST_HEIGHT = 13'd480;
  localparam logic [BAVG_FAC_BITS-1:0] BAVG_RST_FACTOR = 5'd2;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_FACTOR = 2'd2,
    REG_NONE   = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_OUT,
    ST_RECALC
  } state_t;

endpackage

// ----- hw/rtl/block_average_downsampler_core.sv -----
// ----------------------------------------------------------------------------
// block_average_downsampler_core
// Tile averaging over a raster pixel stream; one partial sum per tile column
// held in a single-port synchronous RAM.
//
//   channel  | handshake          | payload
//   ---------+--------------------+---------------------------------------
//   in       | in_valid/in_ready  | in_pixel_value, in_frame_start
//   out      | out_valid/out_ready| out_tile_row, out_tile_col, out_tile_mean
//   cfg      | APB psel/penable   | paddr, pwdata, prdata
//
// A pixel passes through a RAM read, then sum and write back. A pixel that
// closes a tile then runs the bit-serial mean divider and loads the output
// register, which can stall on out_ready.
// A factor register write runs a serial rescan of the tile position counters
// with in_ready low.
// rst_n is synchronous; RAM contents are not cleared.
// ----------------------------------------------------------------------------
module block_average_downsampler_core
  import bavg_pkg::*;
#(
  parameter int MAX_WIDTH = BAVG_MAX_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_pixel_value,
  input  logic        in_frame_start,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] out_tile_row,
  output logic [11:0] out_tile_col,
  output logic [7:0]  out_tile_mean,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int XW   = $clog2(MAX_WIDTH);
  localparam int YW   = BAVG_ROW_BITS;
  localparam int CMPW = (XW + 1 > BAVG_DIM_BITS) ? XW + 1 : BAVG_DIM_BITS;
  localparam int RCW  = (XW > YW) ? XW : YW;
  localparam int RCCW = $clog2(RCW + 1);
  localparam int OW   = BAVG_OFF_BITS;
  localparam int FW   = BAVG_FAC_BITS;
  localparam int SW   = BAVG_SUM_BITS;
  localparam int CW   = BAVG_CNT_BITS;
  localparam int PIX_MAX = (1 << BAVG_PIX_BITS) - 1;

  // configuration
  logic [BAVG_DIM_BITS-1:0] width_r, height_r;
  logic [FW-1:0]            factor_r;
  logic                     wr_en;
  reg_idx_t                 wr_idx;
  logic [BAVG_DIM_BITS-1:0] wr_dim;
  logic [FW-1:0]            wr_fac;
  logic                     pend_r;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign wr_idx = reg_idx_t'(paddr[3:2]);
  assign wr_dim = pwdata[BAVG_DIM_BITS-1:0];
  assign wr_fac = pwdata[FW-1:0];

  always_comb begin
    unique case (wr_idx)
      REG_WIDTH:  prdata = 32'(width_r);
      REG_HEIGHT: prdata = 32'(height_r);
      REG_FACTOR: prdata = 32'(factor_r);
      default:    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= BAVG_RST_WIDTH;
      height_r <= BAVG_RST_HEIGHT;
      factor_r <= BAVG_RST_FACTOR;
    end else if (wr_en) begin
      unique case (wr_idx)
        REG_WIDTH: begin
          if (wr_dim != '0)
            width_r <= (32'(wr_dim) > 32'(MAX_WIDTH)) ? BAVG_DIM_BITS'(MAX_WIDTH) : wr_dim;
        end
        REG_HEIGHT: begin
          if (wr_dim != '0)
            height_r <= (32'(wr_dim) > 32'(BAVG_ROW_LIMIT)) ?
                        BAVG_DIM_BITS'(BAVG_ROW_LIMIT) : wr_dim;
        end
        REG_FACTOR: begin
          if (wr_fac != '0)
            factor_r <= (32'(wr_fac) > 32'(BAVG_MAX_FACTOR)) ?
                        FW'(BAVG_MAX_FACTOR) : wr_fac;
        end
        default: ;
      endcase
    end
  end

  // position state
  state_t          state_r, state_nxt;
  logic [XW-1:0]   x_r, tc_r;
  logic [OW-1:0]   xm_r, ym_r, ox_r, oy_r;
  logic [YW-1:0]   y_r, tr_r;

  // rescan divider
  logic [RCCW-1:0] rc_cnt_r;
  logic [RCW-1:0]  rc_xn_r, rc_yn_r;
  logic [FW-1:0]   rc_xr_r, rc_yr_r;
  logic [FW:0]     rc_xt, rc_yt;
  logic            rc_xge, rc_yge, rc_load, rc_done;

  assign rc_load = pend_r && (state_r == ST_IDLE || state_r == ST_RECALC);
  assign rc_done = (state_r == ST_RECALC) && !pend_r && (rc_cnt_r == RCCW'(RCW));
  assign rc_xt   = {rc_xr_r, rc_xn_r[RCW-1]};
  assign rc_yt   = {rc_yr_r, rc_yn_r[RCW-1]};
  assign rc_xge  = rc_xt >= {1'b0, factor_r};
  assign rc_yge  = rc_yt >= {1'b0, factor_r};

  always_ff @(posedge clk) begin
    if (rc_load) begin
      rc_cnt_r <= '0;
      rc_xn_r  <= RCW'(x_r);
      rc_yn_r  <= RCW'(y_r);
      rc_xr_r  <= '0;
      rc_yr_r  <= '0;
    end else if (state_r == ST_RECALC) begin
      rc_cnt_r <= rc_cnt_r + 1'b1;
      rc_xn_r  <= {rc_xn_r[RCW-2:0], rc_xge};
      rc_yn_r  <= {rc_yn_r[RCW-2:0], rc_yge};
      rc_xr_r  <= rc_xge ? FW'(rc_xt - {1'b0, factor_r}) : rc_xt[FW-1:0];
      rc_yr_r  <= rc_yge ? FW'(rc_yt - {1'b0, factor_r}) : rc_yt[FW-1:0];
    end
  end

  // accept-time position logic
  logic             acc;
  logic [XW-1:0]    cx, ctc;
  logic [YW-1:0]    cy, ctr;
  logic [OW-1:0]    cxm, cym, cox, coy;
  logic [FW-1:0]    cox1, coy1, cxm1, cym1;
  logic             x_end, y_end, lx_off, ly_off, c_first, c_emit;
  logic [2*FW-1:0]  c_count;

  assign in_ready = (state_r == ST_IDLE) && !pend_r;
  assign acc      = in_valid && in_ready;

  always_comb begin
    cx  = in_frame_start ? '0 : x_r;
    cy  = in_frame_start ? '0 : y_r;
    ctc = in_frame_start ? '0 : tc_r;
    ctr = in_frame_start ? '0 : tr_r;
    cxm = in_frame_start ? '0 : xm_r;
    cym = in_frame_start ? '0 : ym_r;
    cox = in_frame_start ? '0 : ox_r;
    coy = in_frame_start ? '0 : oy_r;
    cox1 = FW'(cox) + 1'b1;
    coy1 = FW'(coy) + 1'b1;
    cxm1 = FW'(cxm) + 1'b1;
    cym1 = FW'(cym) + 1'b1;
    lx_off  = cox1 >= factor_r;
    ly_off  = coy1 >= factor_r;
    x_end   = (CMPW'(cx) + 1'b1) >= CMPW'(width_r);
    y_end   = ({1'b0, cy} + 1'b1) >= height_r;
    c_first = (cox == '0) && (coy == '0);
    c_emit  = (lx_off || x_end) && (ly_off || y_end);
    c_count = cox1 * coy1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r  <= '0;
      y_r  <= '0;
      tc_r <= '0;
      tr_r <= '0;
      xm_r <= '0;
      ym_r <= '0;
      ox_r <= '0;
      oy_r <= '0;
    end else if (rc_done) begin
      tc_r <= XW'(rc_xn_r);
      tr_r <= YW'(rc_yn_r);
      xm_r <= OW'(rc_xr_r);
      ym_r <= OW'(rc_yr_r);
    end else if (acc) begin
      if (x_end) begin
        x_r  <= '0;
        tc_r <= '0;
        xm_r <= '0;
        ox_r <= '0;
        if (y_end) begin
          y_r  <= '0;
          tr_r <= '0;
          ym_r <= '0;
          oy_r <= '0;
        end else begin
          y_r  <= cy + 1'b1;
          if (cym1 == factor_r) begin
            ym_r <= '0;
            tr_r <= ctr + 1'b1;
          end else begin
            ym_r <= OW'(cym1);
            tr_r <= ctr;
          end
          oy_r <= ly_off ? '0 : OW'(coy1);
        end
      end else begin
        x_r <= cx + 1'b1;
        if (cxm1 == factor_r) begin
          xm_r <= '0;
          tc_r <= ctc + 1'b1;
        end else begin
          xm_r <= OW'(cxm1);
          tc_r <= ctc;
        end
        ox_r <= lx_off ? '0 : OW'(cox1);
        y_r  <= cy;
        tr_r <= ctr;
        ym_r <= cym;
        oy_r <= coy;
      end
    end
  end

  // item registers and tile sum RAM
  logic [SW-1:0]    mem [MAX_WIDTH];
  logic [SW-1:0]    rd_data_r;
  logic [7:0]       pix_r;
  logic [XW-1:0]    it_tc_r;
  logic [YW-1:0]    it_tr_r;
  logic             first_r, emit_r;
  logic [CW-1:0]    count_r;
  logic [SW-1:0]    sum;

  assign sum = first_r ? SW'(pix_r) : SW'(rd_data_r + SW'(pix_r));

  always_ff @(posedge clk) begin
    if (acc) begin
      rd_data_r <= mem[ctc];
      pix_r     <= in_pixel_value;
      it_tc_r   <= ctc;
      it_tr_r   <= ctr;
      first_r   <= c_first;
      emit_r    <= c_emit;
      count_r   <= CW'(c_count);
    end
    if (state_r == ST_SUM)
      mem[it_tc_r] <= sum;
  end

  // mean divider, restoring, one quotient bit per cycle
  logic [3:0]       dv_cnt_r;
  logic [SW-1:0]    dv_num_r;
  logic [CW-1:0]    dv_rem_r;
  logic [CW:0]      dv_t;
  logic             dv_ge;
  logic [7:0]       mean;

  assign dv_t  = {dv_rem_r, dv_num_r[SW-1]};
  assign dv_ge = dv_t >= {1'b0, count_r};
  assign mean  = (dv_num_r > SW'(PIX_MAX)) ? 8'(PIX_MAX) : dv_num_r[7:0];

  always_ff @(posedge clk) begin
    if (state_r == ST_SUM) begin
      dv_cnt_r <= '0;
      dv_num_r <= sum;
      dv_rem_r <= '0;
    end else if (state_r == ST_DIV) begin
      dv_cnt_r <= dv_cnt_r + 1'b1;
      dv_num_r <= {dv_num_r[SW-2:0], dv_ge};
      dv_rem_r <= dv_ge ? CW'(dv_t - {1'b0, count_r}) : dv_t[CW-1:0];
    end
  end

  // output register
  logic out_valid_r, out_load;

  assign out_load  = (state_r == ST_OUT) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n)
      out_valid_r <= 1'b0;
    else if (out_load)
      out_valid_r <= 1'b1;
    else if (out_ready)
      out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tile_row  <= 12'(it_tr_r);
      out_tile_col  <= 12'(it_tc_r);
      out_tile_mean <= mean;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (wr_en && wr_idx == REG_FACTOR)
        pend_r <= 1'b1;
      else if (rc_load)
        pend_r <= 1'b0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (pend_r)
          state_nxt = ST_RECALC;
        else if (acc)
          state_nxt = ST_SUM;
      end
      ST_SUM:    state_nxt = emit_r ? ST_DIV : ST_IDLE;
      ST_DIV:    if (dv_cnt_r == 4'(SW - 1)) state_nxt = ST_OUT;
      ST_OUT:    if (out_load) state_nxt = ST_IDLE;
      ST_RECALC: if (rc_done) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ----- verif/block_average_downsampler_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// block_average_downsampler_core_tb
// Self-checking bench for the tile averaging core. Reset values are read back,
// then a stimulus table with hand-worked tile means, register edge writes with
// read-back, frames with register changes mid-band, and random geometries with
// random stalls on both channels. Every output transfer is compared in order
// against a hand-worked mean or a tile-sum predictor run alongside the core.
// ----------------------------------------------------------------------------
module block_average_downsampler_core_tb
  import bavg_pkg::*;
();

  localparam int CLK_HALF      = 10;
  localparam int LIMIT_CYCLES  = 400000;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_ITEMS  = 560;
  localparam int TABLE_ROWS    = 19;

  typedef struct packed {
    logic [11:0] row;
    logic [11:0] col;
    logic [7:0]  mean;
  } tile_result_t;

  typedef struct packed {
    logic [7:0]  pix;
    logic        fs;
    logic        typed;
    logic [11:0] row;
    logic [11:0] col;
    logic [7:0]  mean;
  } pixel_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_pixel_value;
  logic        in_frame_start;
  logic        out_valid;
  logic        out_ready;
  logic [11:0] out_tile_row;
  logic [11:0] out_tile_col;
  logic [7:0]  out_tile_mean;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  block_average_downsampler_core #(
    .MAX_WIDTH(BAVG_MAX_WIDTH)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pixel_value (in_pixel_value),
    .in_frame_start (in_frame_start),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_tile_row   (out_tile_row),
    .out_tile_col   (out_tile_col),
    .out_tile_mean  (out_tile_mean),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  // predictor state
  logic [12:0] img_width;
  logic [12:0] img_height;
  logic [4:0]  tile_factor;
  int unsigned col_pos;
  int unsigned row_pos;
  int unsigned off_x;
  int unsigned off_y;
  int unsigned col_sums [BAVG_MAX_WIDTH];

  tile_result_t tile_means_q[$];
  int           fail_count = 0;
  int           cycle_count = 0;
  int           random_sent = 0;
  bit           no_idle = 1'b0;

  pixel_row_t   pixel_table [TABLE_ROWS];

  function automatic void apply_reg_write(input reg_idx_t idx, input logic [31:0] data);
    logic [12:0] dim;
    logic [4:0]  fac;
    dim = data[12:0];
    fac = data[4:0];
    case (idx)
      REG_WIDTH: begin
        if (dim != 0) img_width = (dim > BAVG_MAX_WIDTH) ? 13'(BAVG_MAX_WIDTH) : dim;
      end
      REG_HEIGHT: begin
        if (dim != 0) img_height = (dim > BAVG_ROW_LIMIT) ? 13'(BAVG_ROW_LIMIT) : dim;
      end
      REG_FACTOR: begin
        if (fac != 0) tile_factor = (fac > BAVG_MAX_FACTOR) ? 5'(BAVG_MAX_FACTOR) : fac;
      end
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] reg_value(input reg_idx_t idx);
    case (idx)
      REG_WIDTH:  return 32'(img_width);
      REG_HEIGHT: return 32'(img_height);
      REG_FACTOR: return 32'(tile_factor);
      default:    return 32'd0;
    endcase
  endfunction

  function automatic bit predict_tile(input logic [7:0] pix, input bit fs,
                                      output tile_result_t res);
    int unsigned f, x, y, tc, sum, count, mean;
    bit last_x, last_y, hit;
    hit = 1'b0;
    res = '0;
    f = tile_factor;
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
      off_x = 0;
      off_y = 0;
    end
    x = col_pos;
    y = row_pos;
    tc = x / f;
    if (tc >= BAVG_MAX_WIDTH) tc = BAVG_MAX_WIDTH - 1;
    if (off_x == 0 && off_y == 0) sum = pix;
    else sum = col_sums[tc] + pix;
    col_sums[tc] = sum;
    last_x = (off_x + 1 >= f) || (x + 1 >= img_width);
    last_y = (off_y + 1 >= f) || (y + 1 >= img_height);
    if (last_x && last_y) begin
      count = (off_x + 1) * (off_y + 1);
      mean = sum / count;
      if (mean > 255) mean = 255;
      res.row = 12'(y / f);
      res.col = 12'(tc);
      res.mean = 8'(mean);
      hit = 1'b1;
    end
    if (x + 1 >= img_width) begin
      col_pos = 0;
      off_x = 0;
      if (y + 1 >= img_height) begin
        row_pos = 0;
        off_y = 0;
      end else begin
        row_pos = y + 1;
        off_y = (off_y + 1 >= f) ? 0 : off_y + 1;
      end
    end else begin
      col_pos = x + 1;
      off_x = (off_x + 1 >= f) ? 0 : off_x + 1;
    end
    return hit;
  endfunction

  task automatic cfg_write(input reg_idx_t idx, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    apply_reg_write(idx, data);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_check(input reg_idx_t idx);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== reg_value(idx)) begin
      $error("prdata reg %s: expected %0d, got %0d", idx.name(), reg_value(idx), prdata);
      fail_count++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_geometry(input int w, input int h, input int f);
    cfg_write(REG_WIDTH,  ($urandom & 32'hFFFF_E000) | 32'(w));
    cfg_write(REG_HEIGHT, ($urandom & 32'hFFFF_E000) | 32'(h));
    cfg_write(REG_FACTOR, ($urandom & 32'hFFFF_FFE0) | 32'(f));
  endtask

  task automatic wait_drained();
    while (tile_means_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_pixel(input logic [7:0] pix, input bit fs, input bit typed,
                            input tile_result_t typed_res);
    int gap;
    bit hit;
    tile_result_t res;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_pixel_value <= pix;
    in_frame_start <= fs;
    do @(posedge clk); while (!in_ready);
    hit = predict_tile(pix, fs, res);
    if (typed) tile_means_q.push_back(typed_res);
    else if (hit) tile_means_q.push_back(res);
  endtask

  task automatic release_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic run_frame(input int n, input bit fs_first, input bit fs_noise);
    logic [7:0] pix;
    bit fs;
    int sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 7);
      pix = (sel == 0) ? 8'd0 : (sel == 1) ? 8'd255 : 8'($urandom_range(0, 255));
      fs = (i == 0 && fs_first) || (fs_noise && $urandom_range(0, 39) == 0);
      if ($urandom_range(0, 63) == 0) begin
        release_input();
        wait_drained();
      end
      send_pixel(pix, fs, 1'b0, '0);
    end
    release_input();
  endtask

  always @(posedge clk) begin
    tile_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (tile_means_q.size() == 0) begin
        $error("unexpected transfer: row %0d col %0d mean %0d",
               out_tile_row, out_tile_col, out_tile_mean);
        fail_count++;
      end else begin
        want = tile_means_q.pop_front();
        if (out_tile_row !== want.row) begin
          $error("tile_row: expected %0d, got %0d", want.row, out_tile_row);
          fail_count++;
        end
        if (out_tile_col !== want.col) begin
          $error("tile_col: expected %0d, got %0d", want.col, out_tile_col);
          fail_count++;
        end
        if (out_tile_mean !== want.mean) begin
          $error("tile_mean: expected %0d, got %0d", want.mean, out_tile_mean);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int gap;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("block_average_downsampler_core_tb NOT OK");
      $finish;
    end
  end

  initial begin
    int w, h, f, n;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_pixel_value = 8'd0;
    in_frame_start = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = 4'd0;
    pwdata         = 32'd0;

    img_width   = BAVG_RST_WIDTH;
    img_height  = BAVG_RST_HEIGHT;
    tile_factor = BAVG_RST_FACTOR;
    col_pos = 0;
    row_pos = 0;
    off_x   = 0;
    off_y   = 0;
    foreach (col_sums[i]) col_sums[i] = 0;

    // 3x3 band, factor 2: clipped right column and bottom row
    pixel_table = '{
      '{8'd255, 1'b1, 1'b0, 12'd0, 12'd0, 8'd0},
      '{8'd255, 1'b0, 1'b0, 12'd0, 12'd0, 8'd0},
      '{8'd0,   1'b0, 1'b0, 12'd0, 12'd0, 8'd0},
      '{8'd255, 1'b0, 1'b0, 12'd0, 12'd0, 8'd0},
      '{8'd255, 1'b0, 1'b1, 12'd0, 12'd0, 8'd255},
      '{8'd0,   1'b0, 1'b1, 12'd0, 12'd1, 8'd0},
      '{8'd0,   1'b0, 1'b0, 12'd0, 12'd0, 8'd0},
      '{8'd0,   1'b0, 1'b1, 12'd1, 12'd0, 8'd0},
      '{8'd17,  1'b0, 1'b1, 12'd1, 12'd1, 8'd17},
      '{8'd200, 1'b0, 1'b0, 12'd0, 12'd0, 8'd0},
      '{8'd100, 1'b0, 1'b0, 12'd0, 12'd0, 8'd0},
      '{8'd50,  1'b1, 1'b0, 12'd0, 12'd0, 8'd0},
      '{8'd51,  1'b0, 1'b0, 12'd0, 12'd0, 8'd0},
      '{8'd9,   1'b0, 1'b0, 12'd0, 12'd0, 8'd0},
      '{8'd52,  1'b0, 1'b0, 12'd0, 12'd0, 8'd0},
      '{8'd53,  1'b0, 1'b0, 12'd0, 12'd0, 8'd0},
      '{8'd1,   1'b0, 1'b0, 12'd0, 12'd0, 8'd0},
      '{8'd254, 1'b0, 1'b0, 12'd0, 12'd0, 8'd0},
      '{8'd3,   1'b0, 1'b0, 12'd0, 12'd0, 8'd0}
    };

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    cfg_check(REG_WIDTH);
    cfg_check(REG_HEIGHT);
    cfg_check(REG_FACTOR);

    set_geometry(3, 3, 2);
    foreach (pixel_table[i]) begin
      send_pixel(pixel_table[i].pix, pixel_table[i].fs, pixel_table[i].typed,
                 '{pixel_table[i].row, pixel_table[i].col, pixel_table[i].mean});
    end
    release_input();
    wait_drained();

    // factor 1 over a full 64-wide row seeds every column sum below 64
    set_geometry(64, 2, 1);
    run_frame(80, 1'b1, 1'b0);
    wait_drained();

    cfg_write(REG_WIDTH, 32'd0);
    cfg_write(REG_HEIGHT, 32'hABCD_E000);
    cfg_write(REG_FACTOR, 32'hFFFF_FFE0);
    cfg_check(REG_WIDTH);
    cfg_check(REG_HEIGHT);
    cfg_check(REG_FACTOR);
    cfg_write(REG_WIDTH, 32'h0000_1FFF);
    cfg_write(REG_HEIGHT, 32'hFFFF_FFFF);
    cfg_write(REG_FACTOR, 32'h0000_001F);
    cfg_check(REG_WIDTH);
    cfg_check(REG_HEIGHT);
    cfg_check(REG_FACTOR);

    cfg_write(REG_HEIGHT, 32'd1);
    run_frame(48, 1'b1, 1'b0);
    wait_drained();
    set_geometry(2, 4096, 16);
    run_frame(64, 1'b1, 1'b0);
    wait_drained();
    set_geometry(1, 1, 1);
    run_frame(10, 1'b1, 1'b0);
    wait_drained();

    // register changes in the middle of a band
    set_geometry(64, 8, 4);
    run_frame(100, 1'b1, 1'b0);
    wait_drained();
    cfg_write(REG_FACTOR, 32'd2);
    run_frame(60, 1'b0, 1'b0);
    wait_drained();
    cfg_write(REG_WIDTH, 32'd40);
    run_frame(60, 1'b0, 1'b0);
    wait_drained();
    cfg_write(REG_FACTOR, 32'd3);
    run_frame(60, 1'b0, 1'b0);
    wait_drained();
    cfg_write(REG_HEIGHT, 32'd3);
    run_frame(60, 1'b0, 1'b0);
    wait_drained();
    cfg_write(REG_FACTOR, 32'd4);
    run_frame(60, 1'b0, 1'b0);
    wait_drained();

    while (random_sent < RANDOM_ITEMS) begin
      no_idle = ($urandom_range(0, 3) == 0);
      f = $urandom_range(1, 16);
      w = $urandom_range(1, 40);
      h = $urandom_range(1, 16);
      case ($urandom_range(0, 9))
        0: begin
          w = 4096;
          h = $urandom_range(1, 2);
        end
        1: begin
          w = $urandom_range(1, 4);
          h = 4096;
        end
        2: begin
          w = 1;
          h = 1;
        end
        3: f = 16;
        4: f = 1;
        default: ;
      endcase
      set_geometry(w, h, f);
      n = $urandom_range(20, 100);
      run_frame(n, 1'b1, 1'b1);
      random_sent += n;
      wait_drained();
    end

    no_idle = 1'b0;
    wait_drained();
    if (tile_means_q.size() != 0) begin
      $error("%0d tile results never arrived", tile_means_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("block_average_downsampler_core_tb OK");
    end else begin
      $display("block_average_downsampler_core_tb NOT OK");
    end
    $finish;
  end

endmodule
